// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue bank RTL.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TPMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TPMQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tpmq_pkg.sv =====
// Package for the two-priority queue bank: field widths, codes and the chain beat type.
// No dependencies.
`timescale 1ns / 1ps

package tpmq_pkg;

  localparam int NUM_QUEUES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int QIDX_W  = 4;
  localparam int TAG_W   = 16;
  localparam int CODE_W  = 2;
  localparam int OCC_W   = 4;
  localparam int ENTRY_W = TAG_W + 1;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_e_t;

  typedef enum logic [CODE_W-1:0] {
    RES_DONE  = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } res_code_t;

  typedef struct packed {
    cmd_e_t              command;
    logic [QIDX_W-1:0]   queue_index;
    logic                urgent;
    logic [TAG_W-1:0]    entry_tag;
    res_code_t           result_code;
    logic [TAG_W-1:0]    taken_tag;
    logic                taken_urgent;
    logic [OCC_W-1:0]    occupancy;
  } beat_t;

endpackage

// ===== design/tpmq_cell.sv =====
// One cell of the queue chain: holds one queue (count, head pointer, entry memory).
// Acts on a passing beat addressed to it and hands the beat to the next cell. Uses tpmq_pkg.
`timescale 1ns / 1ps

module tpmq_cell
  import tpmq_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  beat_valid_i,
  input  beat_t beat_i,
  output logic  beat_valid_o,
  output beat_t beat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] word_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic             beat_valid_r;
  beat_t            beat_r, beat_nxt;

  logic               match;
  logic               we;
  logic [PTR_W-1:0]   waddr;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail_slot;

  always_comb begin
    match = 1'b0;
    for (int k = 0; k < (1 << QIDX_W); k++) begin
      if (int'(beat_i.queue_index) == IDX + k * NUM_QUEUES) match = 1'b1;
    end
  end

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(cnt_r);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    tail_slot = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    we       = 1'b0;
    waddr    = tail_slot;
    beat_nxt = beat_i;
    if (beat_valid_i && match) begin
      unique case (beat_i.command)
        CMD_ADD: begin
          if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
            beat_nxt.result_code = RES_FULL;
          end else begin
            we = 1'b1;
            if (beat_i.urgent) begin
              head_nxt = (head_r == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_r - 1'b1;
              waddr    = head_nxt;
            end
            cnt_nxt = cnt_r + 1'b1;
            beat_nxt.result_code = RES_DONE;
          end
          beat_nxt.taken_tag    = '0;
          beat_nxt.taken_urgent = 1'b0;
        end
        CMD_TAKE: begin
          if (cnt_r == '0) begin
            beat_nxt.result_code  = RES_EMPTY;
            beat_nxt.taken_tag    = '0;
            beat_nxt.taken_urgent = 1'b0;
          end else begin
            beat_nxt.result_code  = RES_DONE;
            beat_nxt.taken_tag    = word_r[TAG_W-1:0];
            beat_nxt.taken_urgent = word_r[TAG_W];
            head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        default: beat_nxt = beat_i;
      endcase
      beat_nxt.occupancy = OCC_W'(cnt_nxt);
    end
  end

  // entry store, registered read at the head slot
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {beat_i.urgent, beat_i.entry_tag};
    word_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      head_r       <= '0;
      beat_valid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      head_r       <= head_nxt;
      beat_valid_r <= beat_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign beat_valid_o = beat_valid_r;
  assign beat_o       = beat_r;

endmodule

// ===== design/two_priority_multi_queue.sv =====
// Bank of NUM_QUEUES bounded deques of QUEUE_DEPTH tagged entries each.
// Input channel (in_*): valid/ready beat carrying command (0 add, 1 take), queue_index,
//   urgent and entry_tag. An urgent add goes to the head, a regular add to the tail.
// Result channel (out_*): valid/ready beat with result_code (0 done, 1 full, 2 empty),
//   taken_tag, taken_urgent and the queue's occupancy after the command.
// Each queue lives in one cell of a chain; an accepted beat walks the chain one cell per
//   cycle and the addressed cell (queue_index mod NUM_QUEUES) carries out the command.
// The result is registered in every cell of the chain and then in the output register.
// Only one beat is in flight at a time: a new beat is taken only once the result beat
//   of the last one has been taken.
// in_ready stays low from acceptance until the result beat is taken, so a stalled
//   receiver simply holds the result and the input.
// Reset (synchronous, rst_n low) empties every queue and drops any beat in flight;
//   in_ready is low while rst_n is low. The entry memories need no clearing since only
//   written slots are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_priority_multi_queue
  import tpmq_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [QIDX_W-1:0] in_queue_index,
  input  logic              in_urgent,
  input  logic [TAG_W-1:0]  in_entry_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_result_code,
  output logic [TAG_W-1:0]  out_taken_tag,
  output logic              out_taken_urgent,
  output logic [OCC_W-1:0]  out_occupancy
);

  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  beat_t             out_beat_r;
  logic              in_acc, out_acc;
  beat_t             in_beat;
  logic [NUM_QUEUES:0] chain_valid;
  beat_t             chain_beat [NUM_QUEUES+1];

  assign in_ready = rst_n && !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;

  always_comb begin
    in_beat.command      = cmd_e_t'(in_command);
    in_beat.queue_index  = in_queue_index;
    in_beat.urgent       = in_urgent;
    in_beat.entry_tag    = in_entry_tag;
    in_beat.result_code  = RES_DONE;
    in_beat.taken_tag    = '0;
    in_beat.taken_urgent = 1'b0;
    in_beat.occupancy    = '0;
  end

  assign chain_valid[0] = in_acc;
  assign chain_beat[0]  = in_beat;

  for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_cell
    tpmq_cell #(
      .IDX         (i),
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .beat_valid_i (chain_valid[i]),
      .beat_i       (chain_beat[i]),
      .beat_valid_o (chain_valid[i+1]),
      .beat_o       (chain_beat[i+1])
    );
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (in_acc) busy_nxt = 1'b1;
    else if (out_acc) busy_nxt = 1'b0;
    if (chain_valid[NUM_QUEUES]) out_valid_nxt = 1'b1;
    else if (out_acc) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[NUM_QUEUES]) out_beat_r <= chain_beat[NUM_QUEUES];
  end

  assign out_valid        = out_valid_r;
  assign out_result_code  = out_beat_r.result_code;
  assign out_taken_tag    = out_beat_r.taken_tag;
  assign out_taken_urgent = out_beat_r.taken_urgent;
  assign out_occupancy    = out_beat_r.occupancy;

  `TPMQ_ASSERT(a_out_needs_busy, out_valid_r |-> busy_r, "result beat without an item in flight")
  `TPMQ_ASSERT(a_single_flight, $countones({chain_valid[NUM_QUEUES:1], out_valid_r}) <= 1, "more than one beat in the chain")
  `TPMQ_ASSERT(a_full_occ, (out_valid_r && out_beat_r.result_code == RES_FULL) |-> (out_beat_r.occupancy == OCC_W'(QUEUE_DEPTH)), "full reject with wrong occupancy")
  `TPMQ_ASSERT(a_reject_clean, (out_valid_r && out_beat_r.result_code != RES_DONE) |-> (out_beat_r.taken_tag == '0 && !out_beat_r.taken_urgent), "reject carries a tag")
  `TPMQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy_r && !out_valid_r), "reset left a beat pending")

endmodule
